/* rtl/led_pulse_width_decoder_top_assert.svh */
// ---------------------------------------------------------------------------
// LED pulse-width decoder assertion macros
// Shared property shapes for the port-level checker; they expect i_clk and
// i_rst_n in the scope of use.
// ---------------------------------------------------------------------------
`ifndef LED_PULSE_WIDTH_DECODER_TOP_ASSERT_SVH
`define LED_PULSE_WIDTH_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define LPWD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle implication failed");

// Next-cycle implication, checked outside reset
`define LPWD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

/* rtl/lpwd_pkg.sv */
// ---------------------------------------------------------------------------
// LED pulse-width decoder package
// Shared widths, register map, reset values, controller types and constants.
// ---------------------------------------------------------------------------
package lpwd_pkg;

    // Frame pulse limit; the counters never go beyond 15 bits
    localparam int unsigned MAX_PULSES = 16384;
    localparam int unsigned PulseCapInt = (MAX_PULSES < 32767) ? MAX_PULSES : 32767;
    localparam logic [14:0] PULSE_CAP = 15'(PulseCapInt);

    // Scaled durations: 15-bit ticks times 10-bit ns per tick
    localparam int NS_W  = 25;
    localparam int SUM_W = 31;

    // Divide by three through a reciprocal, exact for 12-bit operands
    localparam logic [11:0] DIV3_MUL   = 12'd2731;
    localparam int          DIV3_SHIFT = 13;

    // Restoring divider steps, one quotient bit per cycle
    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Configuration port
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_TICK_NS          = 3'd0,
        REG_MIN_HIGH_NS      = 3'd1,
        REG_MAX_HIGH_NS      = 3'd2,
        REG_MAX_LOW_NS       = 3'd3,
        REG_ONE_SPLIT_NS     = 3'd4,
        REG_MIN_FRAME_PULSES = 3'd5
    } t_reg_idx;

    localparam logic [9:0]  RST_TICK_NS          = 10'd100;
    localparam logic [15:0] RST_MIN_HIGH_NS      = 16'd50;
    localparam logic [15:0] RST_MAX_HIGH_NS      = 16'd2000;
    localparam logic [23:0] RST_MAX_LOW_NS       = 24'd50000;
    localparam logic [15:0] RST_ONE_SPLIT_NS     = 16'd500;
    localparam logic [14:0] RST_MIN_FRAME_PULSES = 15'd10;

    typedef struct packed {
        logic [9:0]  tick_ns;
        logic [15:0] min_high_ns;
        logic [15:0] max_high_ns;
        logic [23:0] max_low_ns;
        logic [15:0] one_split_ns;
        logic [14:0] min_frame_pulses;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_EVAL,
        ST_DIV_ZERO,
        ST_WAIT_ZERO,
        ST_DIV_ONE,
        ST_WAIT_ONE,
        ST_SUMMARY
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic mul;
        logic update;
        logic div_start;
        logic div_sel;
        logic latch_zero;
        logic latch_one;
        logic load_summary;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic byte_emit;
        logic frame_end;
        logic out_free;
        logic div_busy;
    } t_sts;

endpackage

/* rtl/lpwd_regs.sv */
// ---------------------------------------------------------------------------
// LED pulse-width decoder configuration registers
// APB-style register file holding the six decode settings.
// ---------------------------------------------------------------------------
module lpwd_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lpwd_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [lpwd_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [lpwd_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready,
    output lpwd_pkg::t_cfg                   o_cfg
);

    lpwd_pkg::t_cfg   r_cfg;
    lpwd_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign w_idx  = lpwd_pkg::t_reg_idx'(paddr[lpwd_pkg::CFG_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Write the addressed register, restore defaults on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tick_ns          <= lpwd_pkg::RST_TICK_NS;
            r_cfg.min_high_ns      <= lpwd_pkg::RST_MIN_HIGH_NS;
            r_cfg.max_high_ns      <= lpwd_pkg::RST_MAX_HIGH_NS;
            r_cfg.max_low_ns       <= lpwd_pkg::RST_MAX_LOW_NS;
            r_cfg.one_split_ns     <= lpwd_pkg::RST_ONE_SPLIT_NS;
            r_cfg.min_frame_pulses <= lpwd_pkg::RST_MIN_FRAME_PULSES;
        end else if (w_wr) begin
            case (w_idx)
                lpwd_pkg::REG_TICK_NS:          r_cfg.tick_ns          <= pwdata[9:0];
                lpwd_pkg::REG_MIN_HIGH_NS:      r_cfg.min_high_ns      <= pwdata[15:0];
                lpwd_pkg::REG_MAX_HIGH_NS:      r_cfg.max_high_ns      <= pwdata[15:0];
                lpwd_pkg::REG_MAX_LOW_NS:       r_cfg.max_low_ns       <= pwdata[23:0];
                lpwd_pkg::REG_ONE_SPLIT_NS:     r_cfg.one_split_ns     <= pwdata[15:0];
                lpwd_pkg::REG_MIN_FRAME_PULSES: r_cfg.min_frame_pulses <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (w_idx)
            lpwd_pkg::REG_TICK_NS:          prdata = {22'd0, r_cfg.tick_ns};
            lpwd_pkg::REG_MIN_HIGH_NS:      prdata = {16'd0, r_cfg.min_high_ns};
            lpwd_pkg::REG_MAX_HIGH_NS:      prdata = {16'd0, r_cfg.max_high_ns};
            lpwd_pkg::REG_MAX_LOW_NS:       prdata = {8'd0, r_cfg.max_low_ns};
            lpwd_pkg::REG_ONE_SPLIT_NS:     prdata = {16'd0, r_cfg.one_split_ns};
            lpwd_pkg::REG_MIN_FRAME_PULSES: prdata = {17'd0, r_cfg.min_frame_pulses};
            default:                        prdata = '0;
        endcase
    end

endmodule

/* rtl/lpwd_div.sv */
// ---------------------------------------------------------------------------
// LED pulse-width decoder divider
// Restoring divider, one quotient bit per cycle, for the average high times.
// ---------------------------------------------------------------------------
module lpwd_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [lpwd_pkg::SUM_W-1:0]   i_dividend,
    input  logic [14:0]                  i_divisor,
    output logic                         o_busy,
    output logic [lpwd_pkg::SUM_W-1:0]   o_quotient
);

    logic                             r_busy;
    logic [lpwd_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [lpwd_pkg::SUM_W-1:0]       r_quo;
    logic [14:0]                      r_rem;
    logic [14:0]                      r_dvs;
    logic [15:0]                      w_trial;
    logic [15:0]                      w_diff;
    logic                             w_qbit;

    // Trial subtract of the divisor from the shifted remainder
    assign w_trial = {r_rem, r_quo[lpwd_pkg::SUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_qbit  = (w_trial >= {1'b0, r_dvs});

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= lpwd_pkg::DIV_CNT_W'(lpwd_pkg::DIV_STEPS - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Shift one quotient bit in per step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[lpwd_pkg::SUM_W-2:0], w_qbit};
            r_rem <= w_qbit ? w_diff[14:0] : w_trial[14:0];
        end
    end

endmodule

/* rtl/lpwd_dp.sv */
// ---------------------------------------------------------------------------
// LED pulse-width decoder datapath
// Pulse scaling, bit decision, frame statistics, averages and result register.
// ---------------------------------------------------------------------------
module lpwd_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lpwd_pkg::t_cfg  i_cfg,
    input  lpwd_pkg::t_cmd  i_cmd,
    output lpwd_pkg::t_sts  o_sts,
    input  logic [14:0]     i_high_ticks,
    input  logic [14:0]     i_low_ticks,
    input  logic            i_frame_end,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic            o_kind,
    output logic [7:0]      o_byte_value,
    output logic [10:0]     o_byte_index,
    output logic [14:0]     o_bit_total,
    output logic [11:0]     o_byte_total,
    output logic [9:0]      o_pixel_total,
    output logic [14:0]     o_zero_total,
    output logic [14:0]     o_one_total,
    output logic [15:0]     o_avg_zero_high_ns,
    output logic [15:0]     o_avg_one_high_ns,
    output logic            o_runt,
    output logic            o_last
);

    localparam int NsW  = lpwd_pkg::NS_W;
    localparam int SumW = lpwd_pkg::SUM_W;

    // Captured request and scaled durations
    logic [14:0]      r_hi_t;
    logic [14:0]      r_lo_t;
    logic             r_end;
    logic [NsW-1:0]   r_hns;
    logic [NsW-1:0]   r_lns;

    // Frame statistics
    logic [7:0]       r_shift;
    logic [14:0]      r_bit_cnt;
    logic [11:0]      r_byte_cnt;
    logic [14:0]      r_pulse_cnt;
    logic [SumW-1:0]  r_zero_sum;
    logic [SumW-1:0]  r_one_sum;
    logic [14:0]      r_zero_cnt;
    logic [14:0]      r_one_cnt;
    logic [15:0]      r_avg_zero;
    logic [15:0]      r_avg_one;

    // Result register
    logic             r_out_valid;
    logic             r_kind;
    logic [7:0]       r_byte_value;
    logic [10:0]      r_byte_index;
    logic [14:0]      r_bit_total;
    logic [11:0]      r_byte_total;
    logic [9:0]       r_pixel_total;
    logic [14:0]      r_zero_total;
    logic [14:0]      r_one_total;
    logic [15:0]      r_avg_zero_out;
    logic [15:0]      r_avg_one_out;
    logic             r_runt;
    logic             r_last;

    logic             w_live;
    logic             w_take;
    logic             w_bit;
    logic [14:0]      n_bit_cnt;
    logic [7:0]       n_shift;
    logic             w_byte_emit;
    logic             w_load_byte;
    logic [SumW:0]    w_sum_add;
    logic [SumW-1:0]  n_sum;
    logic [23:0]      w_pix_prod;
    logic [SumW-1:0]  w_div_dvd;
    logic [14:0]      w_div_dvs;
    logic             w_div_busy;
    logic [SumW-1:0]  w_div_quo;

    // Judge the scaled pulse against the window and the split
    assign w_live      = (r_pulse_cnt < lpwd_pkg::PULSE_CAP);
    assign w_take      = w_live
                         && (r_hns >= {9'd0, i_cfg.min_high_ns})
                         && (r_hns <= {9'd0, i_cfg.max_high_ns})
                         && (r_lns <= {1'b0, i_cfg.max_low_ns});
    assign w_bit       = (r_hns > {9'd0, i_cfg.one_split_ns});
    assign n_bit_cnt   = (r_bit_cnt == '1) ? r_bit_cnt : r_bit_cnt + 1'b1;
    assign n_shift     = {r_shift[6:0], w_bit};
    assign w_byte_emit = w_take && (n_bit_cnt[2:0] == 3'd0);
    assign w_load_byte = i_cmd.update && w_byte_emit;

    // Saturating add of the high time into the sum of its bit value
    assign w_sum_add = (w_bit ? {1'b0, r_one_sum} : {1'b0, r_zero_sum})
                       + {{(SumW + 1 - NsW){1'b0}}, r_hns};
    assign n_sum     = w_sum_add[SumW] ? {SumW{1'b1}} : w_sum_add[SumW-1:0];

    // Byte count divided by three
    assign w_pix_prod = {12'd0, r_byte_cnt} * {12'd0, lpwd_pkg::DIV3_MUL};

    // Share one divider between the two averages
    assign w_div_dvd = i_cmd.div_sel ? r_one_sum : r_zero_sum;
    assign w_div_dvs = i_cmd.div_sel ? r_one_cnt : r_zero_cnt;

    lpwd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_busy     (w_div_busy),
        .o_quotient (w_div_quo)
    );

    assign o_sts.byte_emit = w_byte_emit;
    assign o_sts.frame_end = r_end;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_sts.div_busy  = w_div_busy;

    // Capture the request and scale both durations
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_hi_t <= i_high_ticks;
            r_lo_t <= i_low_ticks;
            r_end  <= i_frame_end;
        end
        if (i_cmd.mul) begin
            r_hns <= {10'd0, r_hi_t} * {15'd0, i_cfg.tick_ns};
            r_lns <= {10'd0, r_lo_t} * {15'd0, i_cfg.tick_ns};
        end
    end

    // Advance the frame statistics, clear them when the summary is loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_summary) begin
            r_shift     <= '0;
            r_bit_cnt   <= '0;
            r_byte_cnt  <= '0;
            r_pulse_cnt <= '0;
            r_zero_sum  <= '0;
            r_one_sum   <= '0;
            r_zero_cnt  <= '0;
            r_one_cnt   <= '0;
        end else if (i_cmd.update && w_live) begin
            r_pulse_cnt <= r_pulse_cnt + 1'b1;
            if (w_take) begin
                r_bit_cnt <= n_bit_cnt;
                if (w_bit) begin
                    r_one_sum <= n_sum;
                    r_one_cnt <= (r_one_cnt == '1) ? r_one_cnt : r_one_cnt + 1'b1;
                end else begin
                    r_zero_sum <= n_sum;
                    r_zero_cnt <= (r_zero_cnt == '1) ? r_zero_cnt : r_zero_cnt + 1'b1;
                end
                if (w_byte_emit) begin
                    r_shift    <= '0;
                    r_byte_cnt <= (r_byte_cnt == '1) ? r_byte_cnt : r_byte_cnt + 1'b1;
                end else begin
                    r_shift <= n_shift;
                end
            end
        end
    end

    // Hold the averages, zero when no bits of that value were seen
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_zero) begin
            r_avg_zero <= (r_zero_cnt == '0) ? 16'd0 : w_div_quo[15:0];
        end
        if (i_cmd.latch_one) begin
            r_avg_one <= (r_one_cnt == '0) ? 16'd0 : w_div_quo[15:0];
        end
    end

    // Result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_byte || i_cmd.load_summary) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load a byte or a frame summary into the result register
    always_ff @(posedge i_clk) begin
        if (w_load_byte) begin
            r_kind         <= 1'b0;
            r_byte_value   <= n_shift;
            r_byte_index   <= r_byte_cnt[10:0];
            r_bit_total    <= '0;
            r_byte_total   <= '0;
            r_pixel_total  <= '0;
            r_zero_total   <= '0;
            r_one_total    <= '0;
            r_avg_zero_out <= '0;
            r_avg_one_out  <= '0;
            r_runt         <= 1'b0;
            r_last         <= !r_end;
        end else if (i_cmd.load_summary) begin
            r_kind         <= 1'b1;
            r_byte_value   <= '0;
            r_byte_index   <= '0;
            r_bit_total    <= r_bit_cnt;
            r_byte_total   <= r_byte_cnt;
            r_pixel_total  <= w_pix_prod[lpwd_pkg::DIV3_SHIFT +: 10];
            r_zero_total   <= r_zero_cnt;
            r_one_total    <= r_one_cnt;
            r_avg_zero_out <= r_avg_zero;
            r_avg_one_out  <= r_avg_one;
            r_runt         <= (r_pulse_cnt < i_cfg.min_frame_pulses);
            r_last         <= 1'b1;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_kind             = r_kind;
    assign o_byte_value       = r_byte_value;
    assign o_byte_index       = r_byte_index;
    assign o_bit_total        = r_bit_total;
    assign o_byte_total       = r_byte_total;
    assign o_pixel_total      = r_pixel_total;
    assign o_zero_total       = r_zero_total;
    assign o_one_total        = r_one_total;
    assign o_avg_zero_high_ns = r_avg_zero_out;
    assign o_avg_one_high_ns  = r_avg_one_out;
    assign o_runt             = r_runt;
    assign o_last             = r_last;

endmodule

/* rtl/lpwd_ctrl.sv */
// ---------------------------------------------------------------------------
// LED pulse-width decoder controller
// Sequences capture, scaling, decode, the two divisions and the summary.
// ---------------------------------------------------------------------------
module lpwd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  lpwd_pkg::t_sts  i_sts,
    output lpwd_pkg::t_cmd  o_cmd
);

    lpwd_pkg::t_state r_state;
    lpwd_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpwd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            lpwd_pkg::ST_IDLE: begin
                // take no request while reset is held
                o_in_ready = i_rst_n;
                if (i_rst_n && i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = lpwd_pkg::ST_MUL;
                end
            end
            lpwd_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = lpwd_pkg::ST_EVAL;
            end
            lpwd_pkg::ST_EVAL: begin
                // hold while a completed byte has nowhere to go
                if (!i_sts.byte_emit || i_sts.out_free) begin
                    o_cmd.update = 1'b1;
                    n_state      = i_sts.frame_end ? lpwd_pkg::ST_DIV_ZERO : lpwd_pkg::ST_IDLE;
                end
            end
            lpwd_pkg::ST_DIV_ZERO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = 1'b0;
                n_state         = lpwd_pkg::ST_WAIT_ZERO;
            end
            lpwd_pkg::ST_WAIT_ZERO: begin
                if (!i_sts.div_busy) begin
                    o_cmd.latch_zero = 1'b1;
                    n_state          = lpwd_pkg::ST_DIV_ONE;
                end
            end
            lpwd_pkg::ST_DIV_ONE: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = 1'b1;
                n_state         = lpwd_pkg::ST_WAIT_ONE;
            end
            lpwd_pkg::ST_WAIT_ONE: begin
                o_cmd.div_sel = 1'b1;
                if (!i_sts.div_busy) begin
                    o_cmd.latch_one = 1'b1;
                    n_state         = lpwd_pkg::ST_SUMMARY;
                end
            end
            lpwd_pkg::ST_SUMMARY: begin
                if (i_sts.out_free) begin
                    o_cmd.load_summary = 1'b1;
                    n_state            = lpwd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lpwd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/led_pulse_width_decoder_top.sv */
// ---------------------------------------------------------------------------
// LED pulse-width decoder top level
// Turns captured pulse widths into bytes and per-frame summaries.
// ---------------------------------------------------------------------------
// Usage:
// - Input channel (i_in_valid/o_in_ready) takes one captured pulse per
//   request: high and low time in ticks plus a frame end mark.
// - Output channel (o_out_valid/i_out_ready) returns decoded bytes and, on
//   the frame end pulse, a summary; a byte from that pulse comes first.
// - A pulse goes through capture, one scaling multiply and decode before
//   the next is accepted; its byte is loaded into the result register at
//   decode, which holds while that register cannot take it.
// - A frame end pulse then runs the two averages in turn through one shared
//   restoring divider at one quotient bit per cycle.
// - The result register holds one result; a new pulse is taken while it
//   waits. A stalled receiver holds the block only when a further result
//   is ready to be loaded.
// - Reset (synchronous, active low) clears the frame statistics, restores
//   the register defaults and empties the result register.
// - Write configuration via the APB-style port only while idle; unchecked.
// ---------------------------------------------------------------------------
module led_pulse_width_decoder_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lpwd_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [lpwd_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [lpwd_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [14:0]                      i_high_ticks,
    input  logic [14:0]                      i_low_ticks,
    input  logic                             i_frame_end,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_kind,
    output logic [7:0]                       o_byte_value,
    output logic [10:0]                      o_byte_index,
    output logic [14:0]                      o_bit_total,
    output logic [11:0]                      o_byte_total,
    output logic [9:0]                       o_pixel_total,
    output logic [14:0]                      o_zero_total,
    output logic [14:0]                      o_one_total,
    output logic [15:0]                      o_avg_zero_high_ns,
    output logic [15:0]                      o_avg_one_high_ns,
    output logic                             o_runt,
    output logic                             o_last
);

    lpwd_pkg::t_cfg w_cfg;
    lpwd_pkg::t_cmd w_cmd;
    lpwd_pkg::t_sts w_sts;

    // Configuration registers
    lpwd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Sequencer
    lpwd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Datapath
    lpwd_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (w_cfg),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_high_ticks       (i_high_ticks),
        .i_low_ticks        (i_low_ticks),
        .i_frame_end        (i_frame_end),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_kind             (o_kind),
        .o_byte_value       (o_byte_value),
        .o_byte_index       (o_byte_index),
        .o_bit_total        (o_bit_total),
        .o_byte_total       (o_byte_total),
        .o_pixel_total      (o_pixel_total),
        .o_zero_total       (o_zero_total),
        .o_one_total        (o_one_total),
        .o_avg_zero_high_ns (o_avg_zero_high_ns),
        .o_avg_one_high_ns  (o_avg_one_high_ns),
        .o_runt             (o_runt),
        .o_last             (o_last)
    );

endmodule

/* rtl/lpwd_checker.sv */
// ---------------------------------------------------------------------------
// LED pulse-width decoder port checker
// Port-level properties of the decoder, attached to the top level by bind.
// ---------------------------------------------------------------------------
`include "led_pulse_width_decoder_top_assert.svh"

module lpwd_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         o_in_ready,
    input  logic         o_out_valid,
    input  logic         i_out_ready,
    input  logic         o_kind,
    input  logic [7:0]   o_byte_value,
    input  logic [10:0]  o_byte_index,
    input  logic [14:0]  o_bit_total,
    input  logic [11:0]  o_byte_total,
    input  logic [15:0]  o_avg_zero_high_ns,
    input  logic         o_runt,
    input  logic         o_last
);

    // A summary closes its request and carries no byte
    `LPWD_ASSERT_IMP(a_summary_shape, o_out_valid && o_kind, o_last && (o_byte_value == 8'd0) && (o_byte_index == 11'd0))

    // A byte result carries no frame statistics
    `LPWD_ASSERT_IMP(a_byte_shape, o_out_valid && !o_kind, (o_bit_total == 15'd0) && (o_byte_total == 12'd0) && (o_avg_zero_high_ns == 16'd0) && !o_runt)

    // Drop ready in the cycle after each accepted pulse
    `LPWD_ASSERT_NXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)

    // Hold a stalled result
    `LPWD_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_kind) && $stable(o_byte_value) && $stable(o_last))

endmodule

bind led_pulse_width_decoder_top lpwd_checker u_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_ready         (o_in_ready),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_kind             (o_kind),
    .o_byte_value       (o_byte_value),
    .o_byte_index       (o_byte_index),
    .o_bit_total        (o_bit_total),
    .o_byte_total       (o_byte_total),
    .o_avg_zero_high_ns (o_avg_zero_high_ns),
    .o_runt             (o_runt),
    .o_last             (o_last)
);

/* dv/led_pulse_width_decoder_top_test.sv */
// ---------------------------------------------------------------------------
// LED pulse-width decoder testbench
// Drives captured pulses into the decoder and writes its registers over the
// APB-style port. A predictor in the bench works out the expected bytes and
// frame summaries, and every result is checked field by field, in order.
// The run covers directed edge pulses, zero scaling, a sweep of register
// settings and random settings.
// ---------------------------------------------------------------------------
module led_pulse_width_decoder_top_test;

    localparam int unsigned LIMIT_CYCLES  = 1_000_000;
    localparam int          SETTLE_CYCLES = 80;
    localparam int          MAX_REPORTS   = 10;

    // One result as seen on the output channel
    typedef struct packed {
        logic        kind;
        logic [7:0]  byte_value;
        logic [10:0] byte_index;
        logic [14:0] bit_total;
        logic [11:0] byte_total;
        logic [9:0]  pixel_total;
        logic [14:0] zero_total;
        logic [14:0] one_total;
        logic [15:0] avg_zero_high_ns;
        logic [15:0] avg_one_high_ns;
        logic        runt;
        logic        last;
    } t_decoded;

    logic                            i_clk;
    logic                            i_rst_n   = 1'b0;
    logic                            psel      = 1'b0;
    logic                            penable   = 1'b0;
    logic                            pwrite    = 1'b0;
    logic [lpwd_pkg::CFG_ADDR_W-1:0] paddr     = '0;
    logic [lpwd_pkg::CFG_DATA_W-1:0] pwdata    = '0;
    logic [lpwd_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;
    logic                            in_valid  = 1'b0;
    logic                            o_in_ready;
    logic [14:0]                     high_ticks = '0;
    logic [14:0]                     low_ticks  = '0;
    logic                            frame_end  = 1'b0;
    logic                            o_out_valid;
    logic                            out_ready  = 1'b0;
    logic                            o_kind;
    logic [7:0]                      o_byte_value;
    logic [10:0]                     o_byte_index;
    logic [14:0]                     o_bit_total;
    logic [11:0]                     o_byte_total;
    logic [9:0]                      o_pixel_total;
    logic [14:0]                     o_zero_total;
    logic [14:0]                     o_one_total;
    logic [15:0]                     o_avg_zero_high_ns;
    logic [15:0]                     o_avg_one_high_ns;
    logic                            o_runt;
    logic                            o_last;

    // Predictor copy of the registers and the frame statistics
    lpwd_pkg::t_cfg cfg;
    logic [7:0]     pend_byte;
    logic [14:0]    bits_seen;
    logic [11:0]    bytes_seen;
    logic [14:0]    pulses_seen;
    logic [30:0]    zero_ns_sum;
    logic [30:0]    one_ns_sum;
    logic [14:0]    zero_bits;
    logic [14:0]    one_bits;

    t_decoded    pending_results[$];
    int          mismatches   = 0;
    int unsigned cycle_count  = 0;
    int          in_idle_pct  = 0;
    int          out_idle_pct = 0;

    led_pulse_width_decoder_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_in_valid         (in_valid),
        .o_in_ready         (o_in_ready),
        .i_high_ticks       (high_ticks),
        .i_low_ticks        (low_ticks),
        .i_frame_end        (frame_end),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (out_ready),
        .o_kind             (o_kind),
        .o_byte_value       (o_byte_value),
        .o_byte_index       (o_byte_index),
        .o_bit_total        (o_bit_total),
        .o_byte_total       (o_byte_total),
        .o_pixel_total      (o_pixel_total),
        .o_zero_total       (o_zero_total),
        .o_one_total        (o_one_total),
        .o_avg_zero_high_ns (o_avg_zero_high_ns),
        .o_avg_one_high_ns  (o_avg_one_high_ns),
        .o_runt             (o_runt),
        .o_last             (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic lpwd_pkg::t_cfg make_cfg(input int unsigned tick, min_high, max_high,
                                                input int unsigned max_low, split, min_pulses);
        lpwd_pkg::t_cfg c;
        c.tick_ns          = tick[9:0];
        c.min_high_ns      = min_high[15:0];
        c.max_high_ns      = max_high[15:0];
        c.max_low_ns       = max_low[23:0];
        c.one_split_ns     = split[15:0];
        c.min_frame_pulses = min_pulses[14:0];
        return c;
    endfunction

    function automatic void clear_frame_stats();
        pend_byte   = '0;
        bits_seen   = '0;
        bytes_seen  = '0;
        pulses_seen = '0;
        zero_ns_sum = '0;
        one_ns_sum  = '0;
        zero_bits   = '0;
        one_bits    = '0;
    endfunction

    function automatic logic [14:0] bump15(input logic [14:0] v);
        return (v == 15'h7FFF) ? v : v + 15'd1;
    endfunction

    // Add a scaled high time, clamping at the top of 31 bits
    function automatic logic [30:0] add_ns(input logic [30:0] s, input logic [31:0] ns);
        logic [31:0] t;
        t = {1'b0, s} + ns;
        return t[31] ? 31'h7FFF_FFFF : t[30:0];
    endfunction

    // Decode one accepted pulse and queue the results it causes
    function automatic void predict_pulse(input logic [14:0] h, l, input logic e);
        logic [31:0] high_ns;
        logic [31:0] low_ns;
        logic        one;
        t_decoded    r;
        high_ns = 32'(h) * 32'(cfg.tick_ns);
        low_ns  = 32'(l) * 32'(cfg.tick_ns);
        if (pulses_seen < lpwd_pkg::PULSE_CAP) begin
            pulses_seen = pulses_seen + 15'd1;
            if (high_ns >= 32'(cfg.min_high_ns) && high_ns <= 32'(cfg.max_high_ns) &&
                low_ns <= 32'(cfg.max_low_ns)) begin
                one = (high_ns > 32'(cfg.one_split_ns));
                if (one) begin
                    one_ns_sum = add_ns(one_ns_sum, high_ns);
                    one_bits   = bump15(one_bits);
                end else begin
                    zero_ns_sum = add_ns(zero_ns_sum, high_ns);
                    zero_bits   = bump15(zero_bits);
                end
                pend_byte = {pend_byte[6:0], one};
                bits_seen = bump15(bits_seen);
                // Emit a byte on every eighth accepted bit
                if (bits_seen[2:0] == 3'd0) begin
                    r            = '0;
                    r.byte_value = pend_byte;
                    r.byte_index = bytes_seen[10:0];
                    r.last       = !e;
                    pending_results.push_back(r);
                    bytes_seen = (bytes_seen == 12'hFFF) ? bytes_seen : bytes_seen + 12'd1;
                    pend_byte  = '0;
                end
            end
        end
        // Close the frame: summary after any byte, then drop the statistics
        if (e) begin
            r                  = '0;
            r.kind             = 1'b1;
            r.bit_total        = bits_seen;
            r.byte_total       = bytes_seen;
            r.pixel_total      = 10'(bytes_seen / 12'd3);
            r.zero_total       = zero_bits;
            r.one_total        = one_bits;
            r.avg_zero_high_ns = (zero_bits != 0) ? 16'(zero_ns_sum / zero_bits) : 16'd0;
            r.avg_one_high_ns  = (one_bits != 0) ? 16'(one_ns_sum / one_bits) : 16'd0;
            r.runt             = (pulses_seen < cfg.min_frame_pulses);
            r.last             = 1'b1;
            pending_results.push_back(r);
            clear_frame_stats();
        end
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Send one pulse request; entered and left at a falling edge
    task automatic send_pulse(input logic [14:0] h, l, input logic e);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid   <= 1'b1;
        high_ticks <= h;
        low_ticks  <= l;
        frame_end  <= e;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_pulse(h, l, e);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every expected result has come out
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input lpwd_pkg::t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            lpwd_pkg::REG_TICK_NS:          cfg.tick_ns          = value[9:0];
            lpwd_pkg::REG_MIN_HIGH_NS:      cfg.min_high_ns      = value[15:0];
            lpwd_pkg::REG_MAX_HIGH_NS:      cfg.max_high_ns      = value[15:0];
            lpwd_pkg::REG_MAX_LOW_NS:       cfg.max_low_ns       = value[23:0];
            lpwd_pkg::REG_ONE_SPLIT_NS:     cfg.one_split_ns     = value[15:0];
            lpwd_pkg::REG_MIN_FRAME_PULSES: cfg.min_frame_pulses = value[14:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Write a full register set once the decoder has gone quiet
    task automatic load_config(input lpwd_pkg::t_cfg c);
        wait_idle();
        write_reg(lpwd_pkg::REG_TICK_NS, 32'(c.tick_ns));
        write_reg(lpwd_pkg::REG_MIN_HIGH_NS, 32'(c.min_high_ns));
        write_reg(lpwd_pkg::REG_MAX_HIGH_NS, 32'(c.max_high_ns));
        write_reg(lpwd_pkg::REG_MAX_LOW_NS, 32'(c.max_low_ns));
        write_reg(lpwd_pkg::REG_ONE_SPLIT_NS, 32'(c.one_split_ns));
        write_reg(lpwd_pkg::REG_MIN_FRAME_PULSES, 32'(c.min_frame_pulses));
    endtask

    // Pick a pulse: mostly inside the current window, some raw noise
    function automatic void pick_pulse(output logic [14:0] h, l);
        int unsigned tick;
        int unsigned lo;
        int unsigned hi;
        int unsigned zero_top;
        int unsigned sub_lo;
        int unsigned sub_hi;
        int unsigned low_top;
        tick = cfg.tick_ns;
        h    = 15'($urandom_range(0, 32767));
        l    = 15'($urandom_range(0, 32767));
        if (tick == 0 || $urandom_range(0, 99) < 12) return;
        lo = (32'(cfg.min_high_ns) + tick - 1) / tick;
        hi = 32'(cfg.max_high_ns) / tick;
        if (hi > 32767) hi = 32767;
        if (lo > hi) return;
        // Aim at a one or a zero, falling back to the whole window
        zero_top = 32'(cfg.one_split_ns) / tick;
        sub_lo   = lo;
        sub_hi   = hi;
        if ($urandom_range(0, 1) == 1) begin
            if (sub_lo < zero_top + 1) sub_lo = zero_top + 1;
        end else begin
            if (sub_hi > zero_top) sub_hi = zero_top;
        end
        if (sub_lo <= sub_hi) begin
            lo = sub_lo;
            hi = sub_hi;
        end
        case ($urandom_range(0, 3))
            0:       h = 15'(lo);
            1:       h = 15'(hi);
            default: h = 15'($urandom_range(lo, hi));
        endcase
        low_top = 32'(cfg.max_low_ns) / tick;
        if (low_top > 32767) low_top = 32767;
        l = ($urandom_range(0, 3) == 0) ? 15'(low_top) : 15'($urandom_range(0, low_top));
    endfunction

    task automatic send_frame(input int n);
        logic [14:0] h;
        logic [14:0] l;
        for (int i = 0; i < n; i++) begin
            pick_pulse(h, l);
            send_pulse(h, l, i == n - 1);
        end
    endtask

    // Random frames, some sized to whole bytes, until enough pulses went in
    task automatic run_frames(input int pulses);
        int sent;
        int n;
        sent = 0;
        while (sent < pulses) begin
            n = ($urandom_range(0, 4) == 0) ? 8 * $urandom_range(1, 3) : $urandom_range(1, 40);
            send_frame(n);
            sent += n;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Window edges, split edge, skipped end pulse, runt and partial bytes
    task automatic test_directed();
        send_pulse(15'd1, 15'd0, 1'b0);
        send_pulse(15'd5, 15'd500, 1'b0);
        send_pulse(15'd6, 15'd0, 1'b0);
        send_pulse(15'd20, 15'd500, 1'b0);
        send_pulse(15'd21, 15'd0, 1'b0);
        send_pulse(15'd0, 15'd0, 1'b0);
        send_pulse(15'd1, 15'd501, 1'b0);
        send_pulse(15'd32767, 15'd32767, 1'b0);
        send_pulse(15'd6, 15'd1, 1'b0);
        send_pulse(15'd1, 15'd1, 1'b0);
        send_pulse(15'd1, 15'd1, 1'b0);
        send_pulse(15'd6, 15'd1, 1'b1);
        send_pulse(15'd6, 15'd3, 1'b0);
        send_pulse(15'd1, 15'd3, 1'b0);
        send_pulse(15'd0, 15'd0, 1'b1);
        send_pulse(15'd10, 15'd10, 1'b1);
    endtask

    // With no scaling every duration reads as zero nanoseconds
    task automatic test_zero_tick();
        load_config(make_cfg(0, 0, 65535, 0, 0, 0));
        send_pulse(15'd32767, 15'd32767, 1'b0);
        send_pulse(15'd0, 15'd0, 1'b0);
        send_pulse(15'h5555, 15'h2AAA, 1'b0);
        send_pulse(15'h2AAA, 15'h5555, 1'b0);
        send_pulse(15'd1, 15'd1, 1'b0);
        send_pulse(15'd100, 15'd7, 1'b0);
        send_pulse(15'd9, 15'd900, 1'b0);
        send_pulse(15'd32767, 15'd0, 1'b1);
        load_config(make_cfg(0, 1, 65535, 0, 0, 0));
        send_pulse(15'd32767, 15'd0, 1'b0);
        send_pulse(15'd3, 15'd3, 1'b1);
    endtask

    task automatic test_config_settings();
        lpwd_pkg::t_cfg settings[7];
        settings[0] = make_cfg(100, 50, 2000, 50000, 500, 10);
        settings[1] = make_cfg(1, 0, 65535, 16777215, 65535, 16384);
        settings[2] = make_cfg(1000, 0, 65535, 16777215, 32767, 1);
        settings[3] = make_cfg(3, 65535, 65535, 0, 0, 0);
        settings[4] = make_cfg(12, 150, 1250, 60000, 625, 24);
        settings[5] = make_cfg(1000, 0, 0, 0, 0, 0);
        settings[6] = make_cfg(7, 300, 900, 100000, 600, 16);
        foreach (settings[i]) begin
            load_config(settings[i]);
            run_frames(30);
        end
    endtask

    task automatic test_random_settings();
        int unsigned min_high;
        int unsigned max_high;
        repeat (8) begin
            min_high = $urandom_range(0, 3000);
            max_high = min_high + $urandom_range(0, 65535 - min_high);
            load_config(make_cfg($urandom_range(1, 1000), min_high, max_high,
                                 $urandom_range(0, 16777215),
                                 $urandom_range(min_high, max_high),
                                 $urandom_range(0, 40)));
            run_frames(35);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void check_field(input string field, input logic [31:0] want, got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch on %s: expected %0d, got %0d", field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_decoded want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result with nothing expected: kind %0d byte %0d",
                             o_kind, o_byte_value);
            end else begin
                want = pending_results.pop_front();
                check_field("kind", want.kind, o_kind);
                check_field("byte_value", want.byte_value, o_byte_value);
                check_field("byte_index", want.byte_index, o_byte_index);
                check_field("bit_total", want.bit_total, o_bit_total);
                check_field("byte_total", want.byte_total, o_byte_total);
                check_field("pixel_total", want.pixel_total, o_pixel_total);
                check_field("zero_total", want.zero_total, o_zero_total);
                check_field("one_total", want.one_total, o_one_total);
                check_field("avg_zero_high_ns", want.avg_zero_high_ns, o_avg_zero_high_ns);
                check_field("avg_one_high_ns", want.avg_one_high_ns, o_avg_one_high_ns);
                check_field("runt", want.runt, o_runt);
                check_field("last", want.last, o_last);
            end
        end
    end

    // Stall the receiver at random
    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        cfg = make_cfg(lpwd_pkg::RST_TICK_NS, lpwd_pkg::RST_MIN_HIGH_NS,
                       lpwd_pkg::RST_MAX_HIGH_NS, lpwd_pkg::RST_MAX_LOW_NS,
                       lpwd_pkg::RST_ONE_SPLIT_NS, lpwd_pkg::RST_MIN_FRAME_PULSES);
        clear_frame_stats();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Sender mostly busy, receiver stalls often
        in_idle_pct  = 6;
        out_idle_pct = 67;
        test_directed();
        test_zero_tick();

        // Sender idles often, receiver mostly ready
        in_idle_pct  = 67;
        out_idle_pct = 6;
        test_config_settings();

        // Full rate on both sides
        in_idle_pct  = 0;
        out_idle_pct = 0;
        test_random_settings();

        wait_idle();
        if (pending_results.size() != 0)
            $display("%0d expected results never arrived", pending_results.size());
        if (mismatches == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* led_pulse_width_decoder_top.f */
+incdir+rtl
rtl/lpwd_pkg.sv
rtl/lpwd_regs.sv
rtl/lpwd_div.sv
rtl/lpwd_dp.sv
rtl/lpwd_ctrl.sv
rtl/led_pulse_width_decoder_top.sv
rtl/lpwd_checker.sv
dv/led_pulse_width_decoder_top_test.sv
